/* design/cis_pkg.sv */
// ----------------------------------------------------------------------------
// cis_pkg
// Shared constants and codes for the core idle residency statistics block.
// ----------------------------------------------------------------------------
package cis_pkg;

  // Default number of monitored cores
  localparam int CORES_DEF = 4;

  // Fixed field widths
  localparam int TS_W   = 64;
  localparam int VAL_W  = 32;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Scaled product width: 64-bit ticks times a 20-bit constant
  localparam int PROD_W = 84;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [31:0] FREQ_RST     = 32'd1000000;

  // Request operations
  localparam logic [1:0] OP_ENTER = 2'd0;
  localparam logic [1:0] OP_LEAVE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;
  localparam logic [1:0] OP_SNAP  = 2'd3;

  // Result groups
  localparam logic [1:0] GRP_TIME = 2'd0;
  localparam logic [1:0] GRP_HIST = 2'd1;
  localparam logic [1:0] GRP_CNT  = 2'd2;
  localparam logic [1:0] GRP_EVT  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_EN_TIME = 3'd0;
  localparam logic [CFG_AW-1:0] REG_EN_HIST = 3'd1;
  localparam logic [CFG_AW-1:0] REG_EN_CNT  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_EN_EVT  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_FREQ    = 3'd4;

endpackage

/* design/cis_if.sv */
// ----------------------------------------------------------------------------
// cis_if
// Channel interfaces: request input, result output, configuration write.
// ----------------------------------------------------------------------------
interface cis_in_if;
  import cis_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      op;
  logic [1:0]      core;
  logic [TS_W-1:0] timestamp;
  modport source (output valid, op, core, timestamp, input ready);
  modport sink   (input valid, op, core, timestamp, output ready);
endinterface

interface cis_out_if;
  import cis_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       group;
  logic [2:0]       index;
  logic [VAL_W-1:0] value;
  logic             last;
  modport source (output valid, group, index, value, last, input ready);
  modport sink   (input valid, group, index, value, last, output ready);
endinterface

interface cis_cfg_if;
  import cis_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* design/cis_ram.sv */
// ----------------------------------------------------------------------------
// cis_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/cis_usec_div.sv */
// ----------------------------------------------------------------------------
// cis_usec_div
// Tick to microsecond scaler: ticks * 1e6 / freq, saturated to 32 bits.
// Multiply, multiply, add, then one restoring quotient bit a cycle.
// ----------------------------------------------------------------------------
module cis_usec_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [cis_pkg::TS_W-1:0] ticks,
  input  logic [31:0]              freq,
  output logic                     done,
  output logic [31:0]              usec
);
  import cis_pkg::*;

  localparam int STEP_W = $clog2(PROD_W);

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_ADD, D_RUN} dstate_t;

  dstate_t           st_r;
  logic [51:0]       plo_r;
  logic [51:0]       phi_r;
  logic [31:0]       thi_r;
  logic [31:0]       f_r;
  logic [PROD_W-1:0] dvd_r;
  logic [31:0]       rem_r;
  logic [31:0]       q_r;
  logic              ovf_r;
  logic [STEP_W-1:0] step_r;
  logic              done_r;
  logic [31:0]       usec_r;

  logic [51:0] lo_prod;
  logic [51:0] hi_prod;
  logic [32:0] trial;
  logic [32:0] trial_sub;
  logic        take;

  // Partial products, one per cycle
  assign lo_prod = ticks[31:0] * USEC_PER_SEC;
  assign hi_prod = thi_r * USEC_PER_SEC;

  // Restoring step
  assign trial     = {rem_r, dvd_r[PROD_W-1]};
  assign take      = (trial >= {1'b0, f_r});
  assign trial_sub = trial - {1'b0, f_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        D_IDLE: begin
          if (start) begin
            plo_r <= lo_prod;
            thi_r <= ticks[63:32];
            f_r   <= (freq == 32'd0) ? 32'd1 : freq;
            st_r  <= D_MUL;
          end
        end
        D_MUL: begin
          phi_r <= hi_prod;
          st_r  <= D_ADD;
        end
        D_ADD: begin
          dvd_r  <= {phi_r, 32'd0} + PROD_W'(plo_r);
          rem_r  <= '0;
          q_r    <= '0;
          ovf_r  <= 1'b0;
          step_r <= '0;
          st_r   <= D_RUN;
        end
        D_RUN: begin
          dvd_r  <= {dvd_r[PROD_W-2:0], 1'b0};
          rem_r  <= take ? trial_sub[31:0] : trial[31:0];
          q_r    <= {q_r[30:0], take};
          ovf_r  <= ovf_r | q_r[31];
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(PROD_W - 1)) begin
            // any quotient bit above bit 31 saturates
            usec_r <= (ovf_r | q_r[31]) ? '1 : {q_r[30:0], take};
            done_r <= 1'b1;
            st_r   <= D_IDLE;
          end
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign usec = usec_r;

endmodule

/* design/core_idle_residency_stats.sv */
// ----------------------------------------------------------------------------
// core_idle_residency_stats
// Per-core idle time, idle-count histogram, idle-entry and event statistics.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : requests {op, core, timestamp}; enter idle, leave idle, add
//             event, snapshot. One request is in flight at a time.
//   out_res : result words {group, index, value, last}, sent only by a
//             snapshot; last marks its final word.
//   cfg_wr  : register writes, always ready; write only while idle.
// Requests: event and ignored requests are done in the idle state; enter
//   (S_E1, S_E2) and leave (S_L1 to S_L4) run as read-modify-write passes
//   over the statistics RAMs, each with one read and one write port.
// Snapshot: each time and histogram word waits on the 84-step quotient loop
//   of the microsecond scaler; idle-entry and event words skip the scaler.
// Results go through one output register; while the receiver stalls, the
//   sequencer holds its next word and the registered word stays put.
// Reset clears all statistics (per-entry valid bits on both RAMs), the idle
//   mask, the time base, and sets the timer frequency to 1000000.
// ----------------------------------------------------------------------------
module core_idle_residency_stats #(
  parameter int CORES = cis_pkg::CORES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cis_in_if.sink    in_req,
  cis_out_if.source out_res,
  cis_cfg_if.sink   cfg_wr
);
  import cis_pkg::*;

  localparam int CIW   = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int CNT_W = $clog2(CORES + 1);
  localparam int D1    = 3 * CORES + 1;
  localparam int A1W   = $clog2(D1);
  localparam int D2    = CORES;
  localparam int A2W   = (CORES > 1) ? $clog2(CORES) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_E1, S_E2, S_L1, S_L2, S_L3, S_L4,
    S_T_RDS, S_T_RDT, S_T_UPD, S_T_CLR,
    S_H_RD, S_H_UPD, S_H_GO,
    S_C_RD, S_C_UPD, S_EV, S_DIV, S_EMIT
  } state_t;

  // Configuration
  logic        en_t_r, en_h_r, en_c_r, en_e_r;
  logic [31:0] freq_r;

  // Control and small state
  state_t            st_r;
  logic [CORES-1:0]  mask_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  hidx_r;
  logic [CNT_W-1:0]  idx_r;
  logic [1:0]        grp_r;
  logic [TS_W-1:0]   hstart_r;
  logic [TS_W-1:0]   hdelta_r;
  logic [TS_W-1:0]   delta_r;
  logic [TS_W-1:0]   ts_r;
  logic [TS_W-1:0]   op64_r;
  logic [1:0]        core_r;
  logic [VAL_W-1:0]  event_r;
  logic [VAL_W-1:0]  emit_val_r;
  logic [D1-1:0]     vld1_r;
  logic [D2-1:0]     vld2_r;
  logic              rd1_ok_r, rd2_ok_r;

  // Output register
  logic             out_valid_r;
  logic [1:0]       out_grp_r;
  logic [2:0]       out_idx_r;
  logic [VAL_W-1:0] out_val_r;
  logic             out_last_r;
  logic             out_load;

  // RAM ports
  logic             we1, we2;
  logic [A1W-1:0]   wa1, ra1;
  logic [A2W-1:0]   wa2, ra2;
  logic [TS_W-1:0]  wd1, q1, d1;
  logic [VAL_W-1:0] wd2, q2, d2;

  logic             div_start, div_done;
  logic [31:0]      div_usec;

  logic [3:0]       en_vec;
  logic             core_ok;
  logic             core_idle;
  logic             idle_i;
  logic             grp_done;
  logic             last_word;
  state_t           next_grp;
  state_t           snap_first;

  // First state of the first enabled group at or after g
  function automatic state_t grp_entry(input logic [2:0] g, input logic [3:0] en);
    state_t s;
    s = S_IDLE;
    if (g == 3'd0 && en[0]) begin
      s = S_T_RDS;
    end else if (g <= 3'd1 && en[1]) begin
      s = S_H_RD;
    end else if (g <= 3'd2 && en[2]) begin
      s = S_C_RD;
    end else if (g <= 3'd3 && en[3]) begin
      s = S_EV;
    end
    return s;
  endfunction

  // RAM 1: idle_total[0..C-1], idle_start[C..2C-1], histogram[2C..3C]
  cis_ram #(.WIDTH(TS_W), .DEPTH(D1)) u_ram_time (
    .clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .raddr(ra1), .rdata(q1)
  );

  // RAM 2: per-core idle entry counts
  cis_ram #(.WIDTH(VAL_W), .DEPTH(D2)) u_ram_cnt (
    .clk(clk), .we(we2), .waddr(wa2), .wdata(wd2), .raddr(ra2), .rdata(q2)
  );

  cis_usec_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .ticks(op64_r),
    .freq(freq_r), .done(div_done), .usec(div_usec)
  );

  // Entries never written read as zero
  assign d1 = rd1_ok_r ? q1 : '0;
  assign d2 = rd2_ok_r ? q2 : '0;

  assign en_vec     = {en_e_r, en_c_r, en_h_r, en_t_r};
  assign core_ok    = (int'(in_req.core) < CORES);
  assign core_idle  = mask_r[CIW'(in_req.core)];
  assign idle_i     = mask_r[CIW'(idx_r)];
  assign snap_first = grp_entry(3'd0, en_vec);
  assign next_grp   = grp_entry({1'b0, grp_r} + 3'd1, en_vec);

  // Output register takes a word when it is empty or being drained
  assign out_load   = (st_r == S_EMIT) && (!out_valid_r || out_res.ready);

  // End of the current group and end of the snapshot
  always_comb begin
    case (grp_r)
      GRP_TIME: grp_done = (idx_r == CNT_W'(CORES - 1));
      GRP_HIST: grp_done = (idx_r == CNT_W'(CORES));
      GRP_CNT:  grp_done = (idx_r == CNT_W'(CORES - 1));
      default:  grp_done = 1'b1;
    endcase
    last_word = grp_done && (next_grp == S_IDLE);
  end

  // RAM access sequencing
  always_comb begin
    we1       = 1'b0;
    wa1       = '0;
    wd1       = '0;
    ra1       = '0;
    we2       = 1'b0;
    wa2       = '0;
    wd2       = '0;
    ra2       = '0;
    div_start = 1'b0;
    case (st_r)
      S_E1: begin
        we1 = 1'b1;
        wa1 = A1W'(CORES) + A1W'(core_r);
        wd1 = ts_r;
        ra1 = A1W'(2 * CORES) + A1W'(hidx_r);
        ra2 = A2W'(core_r);
      end
      S_E2: begin
        we1 = en_h_r;
        wa1 = A1W'(2 * CORES) + A1W'(hidx_r);
        wd1 = d1 + hdelta_r;
        we2 = en_c_r;
        wa2 = A2W'(core_r);
        wd2 = d2 + 1'b1;
      end
      S_L1: ra1 = A1W'(CORES) + A1W'(core_r);
      S_L2: ra1 = A1W'(core_r);
      S_L3: begin
        we1 = en_t_r;
        wa1 = A1W'(core_r);
        wd1 = d1 + delta_r;
        ra1 = A1W'(2 * CORES) + A1W'(hidx_r);
      end
      S_L4: begin
        we1 = en_h_r;
        wa1 = A1W'(2 * CORES) + A1W'(hidx_r);
        wd1 = d1 + hdelta_r;
      end
      S_T_RDS: ra1 = A1W'(CORES) + A1W'(idx_r);
      S_T_RDT: ra1 = A1W'(idx_r);
      S_T_UPD: begin
        we1 = idle_i;
        wa1 = A1W'(CORES) + A1W'(idx_r);
        wd1 = ts_r;
      end
      S_T_CLR: begin
        we1       = 1'b1;
        wa1       = A1W'(idx_r);
        div_start = 1'b1;
      end
      S_H_RD: ra1 = A1W'(2 * CORES) + A1W'(idx_r);
      S_H_UPD: begin
        we1 = 1'b1;
        wa1 = A1W'(2 * CORES) + A1W'(idx_r);
      end
      S_H_GO: div_start = 1'b1;
      S_C_RD: ra2 = A2W'(idx_r);
      S_C_UPD: begin
        we2 = 1'b1;
        wa2 = A2W'(idx_r);
      end
      default: ;
    endcase
  end

  // Sequencer, small state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      en_t_r      <= 1'b0;
      en_h_r      <= 1'b0;
      en_c_r      <= 1'b0;
      en_e_r      <= 1'b0;
      freq_r      <= FREQ_RST;
      mask_r      <= '0;
      cnt_r       <= '0;
      hstart_r    <= '0;
      event_r     <= '0;
      vld1_r      <= '0;
      vld2_r      <= '0;
      rd1_ok_r    <= 1'b0;
      rd2_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Valid bits follow RAM writes and reads
      if (we1) begin
        vld1_r[wa1] <= 1'b1;
      end
      if (we2) begin
        vld2_r[wa2] <= 1'b1;
      end
      rd1_ok_r <= vld1_r[ra1];
      rd2_ok_r <= vld2_r[ra2];

      // Configuration writes
      if (cfg_wr.valid) begin
        unique case (cfg_wr.addr)
          REG_EN_TIME: en_t_r <= cfg_wr.data[0];
          REG_EN_HIST: en_h_r <= cfg_wr.data[0];
          REG_EN_CNT:  en_c_r <= cfg_wr.data[0];
          REG_EN_EVT:  en_e_r <= cfg_wr.data[0];
          REG_FREQ:    freq_r <= cfg_wr.data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (st_r)
        S_IDLE: begin
          if (in_req.valid) begin
            ts_r   <= in_req.timestamp;
            core_r <= in_req.core;
            idx_r  <= '0;
            hidx_r <= cnt_r;
            case (in_req.op)
              OP_ENTER: begin
                if (core_ok && !core_idle) begin
                  mask_r[CIW'(in_req.core)] <= 1'b1;
                  cnt_r    <= cnt_r + 1'b1;
                  hdelta_r <= in_req.timestamp - hstart_r;
                  hstart_r <= in_req.timestamp;
                  st_r     <= S_E1;
                end
              end
              OP_LEAVE: begin
                if (core_ok && core_idle) begin
                  mask_r[CIW'(in_req.core)] <= 1'b0;
                  cnt_r    <= cnt_r - 1'b1;
                  hdelta_r <= in_req.timestamp - hstart_r;
                  hstart_r <= in_req.timestamp;
                  st_r     <= S_L1;
                end
              end
              OP_EVENT: begin
                if (en_e_r) begin
                  event_r <= event_r + 1'b1;
                end
              end
              default: begin
                hdelta_r <= in_req.timestamp - hstart_r;
                hstart_r <= in_req.timestamp;
                st_r     <= snap_first;
              end
            endcase
          end
        end
        S_E1: st_r <= S_E2;
        S_E2: st_r <= S_IDLE;
        S_L1: st_r <= S_L2;
        S_L2: begin
          delta_r <= ts_r - d1;
          st_r    <= S_L3;
        end
        S_L3: st_r <= S_L4;
        S_L4: st_r <= S_IDLE;
        // Idle time group
        S_T_RDS: begin
          grp_r <= GRP_TIME;
          st_r  <= S_T_RDT;
        end
        S_T_RDT: begin
          delta_r <= ts_r - d1;
          st_r    <= S_T_UPD;
        end
        S_T_UPD: begin
          op64_r <= idle_i ? (d1 + delta_r) : d1;
          st_r   <= S_T_CLR;
        end
        S_T_CLR: st_r <= S_DIV;
        // Histogram group; the open interval lands on the current count
        S_H_RD: begin
          grp_r <= GRP_HIST;
          st_r  <= S_H_UPD;
        end
        S_H_UPD: begin
          op64_r <= (idx_r == cnt_r) ? (d1 + hdelta_r) : d1;
          st_r   <= S_H_GO;
        end
        S_H_GO: st_r <= S_DIV;
        // Idle entry group
        S_C_RD: begin
          grp_r <= GRP_CNT;
          st_r  <= S_C_UPD;
        end
        S_C_UPD: begin
          emit_val_r <= d2;
          st_r       <= S_EMIT;
        end
        // Event word
        S_EV: begin
          grp_r      <= GRP_EVT;
          idx_r      <= '0;
          emit_val_r <= event_r;
          event_r    <= '0;
          st_r       <= S_EMIT;
        end
        S_DIV: begin
          if (div_done) begin
            emit_val_r <= div_usec;
            st_r       <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_grp_r   <= grp_r;
            out_idx_r   <= 3'(idx_r);
            out_val_r   <= emit_val_r;
            out_last_r  <= last_word;
            if (!grp_done) begin
              idx_r <= idx_r + 1'b1;
              case (grp_r)
                GRP_TIME: st_r <= S_T_RDS;
                GRP_HIST: st_r <= S_H_RD;
                default:  st_r <= S_C_RD;
              endcase
            end else begin
              idx_r <= '0;
              st_r  <= next_grp;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_req.ready  = (st_r == S_IDLE);
  assign cfg_wr.ready  = 1'b1;
  assign out_res.valid = out_valid_r;
  assign out_res.group = out_grp_r;
  assign out_res.index = out_idx_r;
  assign out_res.value = out_val_r;
  assign out_res.last  = out_last_r;

endmodule

/* design/cis_checker.sv */
// ----------------------------------------------------------------------------
// cis_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cis_checker #(
  parameter int CORES = 4
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_group,
  input logic [2:0]  out_index,
  input logic [31:0] out_value,
  input logic        out_last
);
  import cis_pkg::*;

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
    $stable(out_group) && $stable(out_index) && $stable(out_last))
    else $error("stalled result word changed");

  // Nothing is shown right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Per-core groups carry a core index in range
  a_core: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_group == GRP_TIME || out_group == GRP_CNT) |->
    int'(out_index) < CORES)
    else $error("core index out of range");

  // The event word is index zero and ends the snapshot
  a_evt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_group == GRP_EVT |-> out_index == 3'd0 && out_last)
    else $error("event word malformed");

endmodule

bind core_idle_residency_stats cis_checker #(.CORES(CORES)) u_cis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_group (out_res.group),
  .out_index (out_res.index),
  .out_value (out_res.value),
  .out_last  (out_res.last)
);
